@@ design/edist_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package edist_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CHAR_W  = 8;
    localparam int ACT_W   = 2;
    localparam int DIST_W  = 7;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [DIST_W-1:0] t_dist;

    localparam t_action ACT_APPEND_FIRST  = 2'd0;
    localparam t_action ACT_APPEND_SECOND = 2'd1;
    localparam t_action ACT_COMPUTE       = 2'd2;

    // clamp a cost value into the distance field
    function automatic t_dist sat_dist(input t_len value);
        logic [LEN_W+DIST_W-1:0] wide;
        wide = (LEN_W + DIST_W)'(value);
        if (wide > (LEN_W + DIST_W)'(DIST_MAX)) begin
            sat_dist = DIST_MAX;
        end else begin
            sat_dist = wide[DIST_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ design/edist_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module edist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ design/edit_distance_engine.sv @@
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_action, i_char_code, i_missing_mark
// out       output     o_out_valid / i_out_ready o_distance, o_missing, o_overflow
//
// Appends and ignored items are taken in the idle state; loads are taken while a result
// waits. A compute fills the cost row, then per second-string character reads it and
// works one cost cell per cycle along the row through the single min/compare unit, bound
// by the one cost-row RAM port pair. An empty or missing string goes straight to done.
// Reset (synchronous, active low) clears lengths, flags and the sequencer; string and
// cost RAMs are not cleared. A stalled result holds the next compute in its final state.
`timescale 1ns / 1ps
`default_nettype none

module edit_distance_engine (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [edist_pkg::ACT_W-1:0]  i_action,
    input  wire logic [edist_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                    i_missing_mark,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [edist_pkg::DIST_W-1:0] o_distance,
    output logic                         o_missing,
    output logic                         o_overflow
);

    import edist_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_ROWRD = 3'd2;
    localparam logic [2:0] ST_ROWCY = 3'd3;
    localparam logic [2:0] ST_CELL  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    t_len       r_first_len, n_first_len;
    t_len       r_second_len, n_second_len;
    logic       r_missing_seen, n_missing_seen;
    logic       r_overflow_seen, n_overflow_seen;
    t_len       r_i, n_i;
    t_len       r_j, n_j;
    t_len       r_left, n_left;
    t_len       r_diag, n_diag;
    t_char      r_cy, n_cy;
    t_len       r_result, n_result;
    logic       r_out_valid, n_out_valid;
    t_dist      r_distance, n_distance;
    logic       r_missing, n_missing;
    logic       r_overflow, n_overflow;

    logic              in_xfer;
    logic              first_we, second_we, cost_we;
    logic [ADDR_W-1:0] text_wr_addr, cell_rd_addr, second_rd_addr, cost_wr_addr;
    t_len              cost_wr_data;
    t_char             first_rdata, second_rdata;
    t_len              cost_rdata;
    t_len              above, cell_cost, min_lr, min_all;
    t_len              i_minus1, j_minus1;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // string loads share the write path; action picks the RAM
    assign first_we  = in_xfer && (i_action == ACT_APPEND_FIRST) && !i_missing_mark
                       && (r_first_len < t_len'(MAX_LEN));
    assign second_we = in_xfer && (i_action == ACT_APPEND_SECOND) && !i_missing_mark
                       && (r_second_len < t_len'(MAX_LEN));
    assign text_wr_addr = (i_action == ACT_APPEND_FIRST) ? r_first_len[ADDR_W-1:0]
                                                         : r_second_len[ADDR_W-1:0];

    assign i_minus1       = r_i - t_len'(1);
    assign j_minus1       = r_j - t_len'(1);
    assign cell_rd_addr   = (r_state == ST_CELL) ? r_i[ADDR_W-1:0] : '0;
    assign second_rd_addr = j_minus1[ADDR_W-1:0];

    // shared cell unit: cost_row[i] = eq ? diag : 1 + min(left, above, diag)
    assign above     = cost_rdata;
    assign min_lr    = (r_left < above) ? r_left : above;
    assign min_all   = (min_lr < r_diag) ? min_lr : r_diag;
    assign cell_cost = (first_rdata == r_cy) ? r_diag : min_all + t_len'(1);

    assign cost_we      = (r_state == ST_INIT) || (r_state == ST_CELL);
    assign cost_wr_addr = (r_state == ST_INIT) ? r_i[ADDR_W-1:0] : i_minus1[ADDR_W-1:0];
    assign cost_wr_data = (r_state == ST_INIT) ? r_i + t_len'(1) : cell_cost;

    edist_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_text (
        .i_clk     (i_clk),
        .i_wr_en   (first_we),
        .i_wr_addr (text_wr_addr),
        .i_wr_data (i_char_code),
        .i_rd_addr (cell_rd_addr),
        .o_rd_data (first_rdata)
    );

    edist_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_text (
        .i_clk     (i_clk),
        .i_wr_en   (second_we),
        .i_wr_addr (text_wr_addr),
        .i_wr_data (i_char_code),
        .i_rd_addr (second_rd_addr),
        .o_rd_data (second_rdata)
    );

    edist_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_cost_row (
        .i_clk     (i_clk),
        .i_wr_en   (cost_we),
        .i_wr_addr (cost_wr_addr),
        .i_wr_data (cost_wr_data),
        .i_rd_addr (cell_rd_addr),
        .o_rd_data (cost_rdata)
    );

    always_comb begin
        n_state         = r_state;
        n_first_len     = r_first_len;
        n_second_len    = r_second_len;
        n_missing_seen  = r_missing_seen;
        n_overflow_seen = r_overflow_seen;
        n_i             = r_i;
        n_j             = r_j;
        n_left          = r_left;
        n_diag          = r_diag;
        n_cy            = r_cy;
        n_result        = r_result;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_distance      = r_distance;
        n_missing       = r_missing;
        n_overflow      = r_overflow;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if ((i_action == ACT_APPEND_FIRST) || (i_action == ACT_APPEND_SECOND)) begin
                        if (i_missing_mark) begin
                            n_missing_seen = 1'b1;
                        end else if (first_we) begin
                            n_first_len = r_first_len + t_len'(1);
                        end else if (second_we) begin
                            n_second_len = r_second_len + t_len'(1);
                        end else begin
                            n_overflow_seen = 1'b1;
                        end
                    end else if (i_action == ACT_COMPUTE) begin
                        if (r_missing_seen) begin
                            n_result = '0;
                            n_state  = ST_DONE;
                        end else if (r_first_len == '0) begin
                            n_result = r_second_len;
                            n_state  = ST_DONE;
                        end else if (r_second_len == '0) begin
                            n_result = r_first_len;
                            n_state  = ST_DONE;
                        end else begin
                            n_i     = '0;
                            n_state = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT: begin
                n_i = r_i + t_len'(1);
                if (r_i + t_len'(1) == r_first_len) begin
                    n_j     = t_len'(1);
                    n_state = ST_ROWRD;
                end
            end
            ST_ROWRD: begin
                n_diag  = j_minus1;
                n_left  = r_j;
                n_state = ST_ROWCY;
            end
            ST_ROWCY: begin
                n_cy    = second_rdata;
                n_i     = t_len'(1);
                n_state = ST_CELL;
            end
            ST_CELL: begin
                n_left = cell_cost;
                n_diag = above;
                if (r_i == r_first_len) begin
                    if (r_j == r_second_len) begin
                        n_result = cell_cost;
                        n_state  = ST_DONE;
                    end else begin
                        n_j     = r_j + t_len'(1);
                        n_state = ST_ROWRD;
                    end
                end else begin
                    n_i = r_i + t_len'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid     = 1'b1;
                    n_distance      = sat_dist(r_result);
                    n_missing       = r_missing_seen;
                    n_overflow      = r_overflow_seen;
                    n_first_len     = '0;
                    n_second_len    = '0;
                    n_missing_seen  = 1'b0;
                    n_overflow_seen = 1'b0;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_first_len     <= '0;
            r_second_len    <= '0;
            r_missing_seen  <= 1'b0;
            r_overflow_seen <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_first_len     <= n_first_len;
            r_second_len    <= n_second_len;
            r_missing_seen  <= n_missing_seen;
            r_overflow_seen <= n_overflow_seen;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_left     <= n_left;
        r_diag     <= n_diag;
        r_cy       <= n_cy;
        r_result   <= n_result;
        r_distance <= n_distance;
        r_missing  <= n_missing;
        r_overflow <= n_overflow;
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_missing   = r_missing;
    assign o_overflow  = r_overflow;

endmodule

`default_nettype wire

@@ design/edist_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module edist_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [edist_pkg::DIST_W-1:0] o_distance,
    input wire logic                         o_missing
);

    import edist_pkg::*;

    // a result waiting for transfer must not vanish
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_missing |-> o_distance == '0)
        else $error("missing result carries nonzero distance");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_distance <= DIST_W'(MAX_LEN)) || (o_distance == DIST_MAX))
        else $error("distance beyond string length");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind edit_distance_engine edist_checker u_edist_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_distance  (o_distance),
    .o_missing   (o_missing)
);

`default_nettype wire

@@ dv/tb_edit_distance_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tb_edit_distance_engine;
    import edist_pkg::*;

    localparam t_action ACT_UNUSED  = 2'd3;
    localparam int      RAND_ITEMS  = 1150;
    localparam int      CYCLE_LIMIT = 2_000_000;
    localparam int      LONG_HOLD   = 400;
    localparam int      DIR_ROWS    = 24;

    typedef struct packed {
        t_dist distance;
        logic  missing;
        logic  overflow;
    } t_dist_result;

    typedef struct packed {
        t_action act;
        t_char   ch;
        logic    mark;
    } t_load_item;

    typedef struct packed {
        t_load_item   item;
        logic         known;
        t_dist_result want;
    } t_plan_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [ACT_W-1:0]  i_action = '0;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic              i_missing_mark = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DIST_W-1:0] o_distance;
    logic              o_missing;
    logic              o_overflow;

    edit_distance_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_char_code   (i_char_code),
        .i_missing_mark(i_missing_mark),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_distance    (o_distance),
        .o_missing     (o_missing),
        .o_overflow    (o_overflow)
    );

    always #1 i_clk = ~i_clk;

    // mirror of the string stores and flags
    t_char first_str [MAX_LEN];
    t_char second_str [MAX_LEN];
    int    first_len;
    int    second_len;
    logic  miss_seen;
    logic  ovf_seen;

    t_dist_result pending_distances [$];
    int           err_count = 0;
    int           cycle_count = 0;
    int           loads_accepted = 0;
    bit           want_long_hold = 1'b0;
    t_plan_row    plan [DIR_ROWS];

    function automatic int levenshtein_cost();
        int row [MAX_LEN+1];
        int diag;
        int above;
        int cur;
        if (first_len == 0) return second_len;
        if (second_len == 0) return first_len;
        for (int i = 0; i <= first_len; i++) row[i] = i;
        for (int j = 1; j <= second_len; j++) begin
            diag = row[0];
            row[0] = j;
            for (int i = 1; i <= first_len; i++) begin
                above = row[i];
                if (first_str[i-1] == second_str[j-1]) begin
                    cur = diag;
                end else begin
                    cur = row[i-1];
                    if (above < cur) cur = above;
                    if (diag < cur) cur = diag;
                    cur = cur + 1;
                end
                row[i] = cur;
                diag = above;
            end
        end
        return row[first_len];
    endfunction

    // returns 1 when the item produces a distance
    function automatic bit apply_item(input t_load_item it, output t_dist_result res);
        int d;
        res = '0;
        case (it.act)
            ACT_APPEND_FIRST: begin
                if (it.mark) begin
                    miss_seen = 1'b1;
                end else if (first_len < MAX_LEN) begin
                    first_str[first_len] = it.ch;
                    first_len++;
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            ACT_APPEND_SECOND: begin
                if (it.mark) begin
                    miss_seen = 1'b1;
                end else if (second_len < MAX_LEN) begin
                    second_str[second_len] = it.ch;
                    second_len++;
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            ACT_COMPUTE: begin
                d = miss_seen ? 0 : levenshtein_cost();
                res.distance = (d > int'(DIST_MAX)) ? DIST_MAX : t_dist'(d);
                res.missing  = miss_seen;
                res.overflow = ovf_seen;
                first_len  = 0;
                second_len = 0;
                miss_seen  = 1'b0;
                ovf_seen   = 1'b0;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_plan_row plain_row(t_action a, t_char c, logic m);
        plain_row = '{'{a, c, m}, 1'b0, '0};
    endfunction

    function automatic t_plan_row known_row(t_action a, t_char c, logic m,
                                            t_dist d, logic miss, logic ovf);
        known_row = '{'{a, c, m}, 1'b1, '{d, miss, ovf}};
    endfunction

    function automatic int send_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(8, 0);
        if (r < 92) return $urandom_range(24, 9);
        return $urandom_range(68, 56);
    endfunction

    function automatic t_char pick_char(bit narrow);
        return narrow ? t_char'($urandom_range(3, 0)) : t_char'($urandom_range(255, 0));
    endfunction

    // valid stays high after the transfer; the caller either offers the next item
    // in the same step or lowers valid
    task automatic send_item(input t_load_item it, input bit known, input t_dist_result want);
        t_dist_result res;
        i_in_valid     <= 1'b1;
        i_action       <= it.act;
        i_char_code    <= it.ch;
        i_missing_mark <= it.mark;
        do @(posedge i_clk); while (!o_in_ready);
        if (apply_item(it, res)) pending_distances.push_back(known ? want : res);
        if (it.act != ACT_UNUSED) loads_accepted++;
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_distances.size() != 0);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d distances outstanding", $time,
                     pending_distances.size());
            $display("tb_edit_distance_engine: FAIL");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready value
    initial begin
        int           hold_left;
        int           burst_left;
        int           r;
        t_dist_result got;
        t_dist_result want;
        hold_left  = 0;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = '{o_distance, o_missing, o_overflow};
                if (pending_distances.size() == 0) begin
                    $display("%0t: unexpected result: distance %0d missing %0b overflow %0b",
                             $time, got.distance, got.missing, got.overflow);
                    err_count++;
                end else begin
                    want = pending_distances.pop_front();
                    if (got.distance !== want.distance) begin
                        $display("%0t: distance mismatch: expected %0d, actual %0d",
                                 $time, want.distance, got.distance);
                        err_count++;
                    end
                    if (got.missing !== want.missing) begin
                        $display("%0t: missing mismatch: expected %0b, actual %0b",
                                 $time, want.missing, got.missing);
                        err_count++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                                 $time, want.overflow, got.overflow);
                        err_count++;
                    end
                end
            end
            if (want_long_hold) begin
                want_long_hold = 1'b0;
                hold_left      = LONG_HOLD;
                burst_left     = 0;
            end
            if (hold_left == 0 && burst_left == 0) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    burst_left = $urandom_range(200, 50);
                end else if (r < 70) begin
                    hold_left = 0;
                end else if (r < 92) begin
                    hold_left = $urandom_range(3, 1);
                end else if (r < 99) begin
                    hold_left = $urandom_range(12, 4);
                end else begin
                    hold_left = $urandom_range(80, 20);
                end
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (burst_left > 0) burst_left--;
            end
        end
    end

    // load side
    initial begin
        t_load_item it;
        t_load_item seq_items [$];
        t_char      text_a [$];
        t_char      text_b [$];
        int         seq_no;
        int         start_count;
        int         la;
        int         lb;
        int         ia;
        int         ib;
        int         r;
        int         p;
        bit         burst;
        bit         narrow;

        first_len  = 0;
        second_len = 0;
        miss_seen  = 1'b0;
        ovf_seen   = 1'b0;

        plan = '{
            known_row(ACT_COMPUTE,       8'h00, 1'b0, 7'd0, 1'b0, 1'b0),
            plain_row(ACT_APPEND_FIRST,  8'h00, 1'b0),
            plain_row(ACT_APPEND_FIRST,  8'hFF, 1'b0),
            plain_row(ACT_APPEND_SECOND, 8'hFF, 1'b0),
            plain_row(ACT_APPEND_SECOND, 8'h00, 1'b0),
            plain_row(ACT_COMPUTE,       8'h00, 1'b0),
            plain_row(ACT_UNUSED,        8'h55, 1'b1),
            plain_row(ACT_APPEND_FIRST,  8'hAA, 1'b0),
            known_row(ACT_COMPUTE,       8'h7F, 1'b0, 7'd1, 1'b0, 1'b0),
            plain_row(ACT_APPEND_SECOND, 8'h5A, 1'b1),
            plain_row(ACT_APPEND_FIRST,  8'h11, 1'b0),
            known_row(ACT_COMPUTE,       8'hFF, 1'b1, 7'd0, 1'b1, 1'b0),
            plain_row(ACT_APPEND_SECOND, 8'h01, 1'b0),
            plain_row(ACT_APPEND_SECOND, 8'h02, 1'b0),
            plain_row(ACT_APPEND_SECOND, 8'h03, 1'b0),
            known_row(ACT_COMPUTE,       8'h00, 1'b0, 7'd3, 1'b0, 1'b0),
            plain_row(ACT_APPEND_FIRST,  8'h80, 1'b1),
            known_row(ACT_COMPUTE,       8'h00, 1'b0, 7'd0, 1'b1, 1'b0),
            known_row(ACT_COMPUTE,       8'h00, 1'b0, 7'd0, 1'b0, 1'b0),
            plain_row(ACT_APPEND_FIRST,  8'h41, 1'b0),
            plain_row(ACT_APPEND_FIRST,  8'h42, 1'b0),
            plain_row(ACT_APPEND_SECOND, 8'h42, 1'b0),
            plain_row(ACT_UNUSED,        8'hAA, 1'b0),
            plain_row(ACT_COMPUTE,       8'h00, 1'b0)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            send_item(plan[k].item, plan[k].known, plan[k].want);
            idle_for(send_gap(1'b0));
        end
        wait_drained();

        seq_no      = 0;
        start_count = loads_accepted;
        while (loads_accepted - start_count < RAND_ITEMS) begin
            burst = ($urandom_range(99) < 20);
            // receiver stalls long while short back-to-back computes keep coming
            if (seq_no == 4) want_long_hold = 1'b1;
            if (seq_no >= 4 && seq_no <= 6) burst = 1'b1;
            if (seq_no % 25 == 12) wait_drained();
            seq_items.delete();
            if (seq_no > 6 && $urandom_range(99) < 15) begin
                repeat ($urandom_range(6, 1)) begin
                    it.act  = t_action'($urandom_range(3, 0));
                    it.ch   = pick_char(1'b0);
                    it.mark = 1'($urandom_range(1));
                    seq_items.push_back(it);
                end
            end else begin
                narrow = 1'($urandom_range(1));
                la = pick_len();
                lb = pick_len();
                // first string past the limit against a full second one, then one full string against an empty one
                if (seq_no == 2) begin
                    la = 66;
                    lb = 64;
                end else if (seq_no == 3) begin
                    la = 64;
                    lb = 0;
                end else if (seq_no >= 4 && seq_no <= 6) begin
                    la = 3;
                    lb = 2;
                end
                text_a.delete();
                repeat (la) text_a.push_back(pick_char(narrow));
                text_b.delete();
                if (seq_no > 3 && $urandom_range(99) < 35) begin
                    text_b = text_a;
                    repeat ($urandom_range(4, 1)) begin
                        r = $urandom_range(2);
                        p = $urandom_range(text_b.size());
                        if (r == 0 && p < text_b.size()) begin
                            text_b[p] = pick_char(narrow);
                        end else if (r == 1 && p < text_b.size()) begin
                            text_b.delete(p);
                        end else begin
                            text_b.insert(p, pick_char(narrow));
                        end
                    end
                end else begin
                    repeat (lb) text_b.push_back(pick_char(narrow));
                end
                ia = 0;
                ib = 0;
                while (ia < text_a.size() || ib < text_b.size()) begin
                    if (ib >= text_b.size() || (ia < text_a.size() && $urandom_range(1) == 0)) begin
                        it.act = ACT_APPEND_FIRST;
                        it.ch  = text_a[ia];
                        ia++;
                    end else begin
                        it.act = ACT_APPEND_SECOND;
                        it.ch  = text_b[ib];
                        ib++;
                    end
                    it.mark = 1'b0;
                    seq_items.push_back(it);
                    r = $urandom_range(99);
                    if (r < 2) begin
                        it.act  = ACT_UNUSED;
                        it.ch   = pick_char(1'b0);
                        it.mark = 1'($urandom_range(1));
                        seq_items.push_back(it);
                    end else if (r < 3) begin
                        it.act  = $urandom_range(1) ? ACT_APPEND_SECOND : ACT_APPEND_FIRST;
                        it.ch   = pick_char(1'b0);
                        it.mark = 1'b1;
                        seq_items.push_back(it);
                    end
                end
                it.act  = ACT_COMPUTE;
                it.ch   = pick_char(1'b0);
                it.mark = 1'($urandom_range(1));
                seq_items.push_back(it);
            end
            foreach (seq_items[k]) begin
                send_item(seq_items[k], 1'b0, '0);
                idle_for(send_gap(burst));
            end
            seq_no++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending_distances.size() == 0) begin
            $display("tb_edit_distance_engine: PASS");
        end else begin
            $display("tb_edit_distance_engine: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
